>>> rtl/core/fsmc_pkg.sv
package fsmc_pkg;

  localparam int unsigned ScaleBitsDefault = 0;
  localparam int unsigned ExpBias          = 126;
  localparam int unsigned ManWidth         = 16;
  localparam int unsigned ShiftMax         = 16;

  typedef enum logic {
    ModeToSignMag = 1'b0,
    ModeToFloat   = 1'b1
  } mode_e;

  typedef struct packed {
    logic        mode;
    logic [31:0] operand;
    logic signed [7:0] offset;
  } in_item_t;

endpackage

>>> rtl/core/fsmc_if.sv
interface fsmc_in_if;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [31:0]       operand;
  logic signed [7:0] offset;

  modport source (output valid, mode, operand, offset, input ready);
  modport sink   (input valid, mode, operand, offset, output ready);
endinterface

interface fsmc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

>>> rtl/core/fsmc_convert.sv
module fsmc_convert #(
  parameter int unsigned ScaleBits = fsmc_pkg::ScaleBitsDefault
) (
  input  fsmc_pkg::in_item_t item_i,
  output logic [31:0]        result_o
);

  logic [7:0]  top;
  logic [7:0]  ex;
  logic [15:0] man;
  logic [8:0]  diff;
  logic [3:0]  sh_lo;
  logic [15:0] shifted;
  logic        rnd;
  logic [15:0] mag0;
  logic [15:0] mag1;
  logic [4:0]  p;
  logic [15:0] frac_sh;
  logic [7:0]  ex1;

  // Window top and mantissa for float to sign-magnitude
  assign top  = 8'(fsmc_pkg::ExpBias + ScaleBits) + item_i.offset;
  assign ex   = item_i.operand[30:23];
  assign man  = {1'b1, item_i.operand[22:8]};
  assign diff = {1'b0, top} - {1'b0, ex};
  assign sh_lo = diff[3:0];

  // Shift right and round half up from the bit below
  always_comb begin
    shifted = man >> sh_lo;
    rnd     = 1'b0;
    if (diff == 9'd16) begin
      shifted = 16'd0;
      rnd     = man[15];
    end else if (sh_lo != 4'd0) begin
      rnd = man[sh_lo - 4'd1];
    end
    mag0 = 16'd0;
    if (!diff[8] && diff <= 9'(fsmc_pkg::ShiftMax)) begin
      mag0 = shifted + 16'(rnd);
    end
  end

  // Leading one detect and fraction placement for sign-magnitude to float
  assign mag1 = item_i.operand[15:0];
  always_comb begin
    p = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (mag1[i]) p = 5'(i + 1);
    end
  end
  // Move the leading one to bit 15; the fraction is taken from the bits below it
  assign frac_sh = mag1 << (5'd16 - p);
  assign ex1 = 8'(fsmc_pkg::ExpBias) + {3'b0, p} + item_i.offset;

  always_comb begin
    case (fsmc_pkg::mode_e'(item_i.mode))
      fsmc_pkg::ModeToSignMag: result_o = {15'd0, item_i.operand[31], mag0};
      fsmc_pkg::ModeToFloat: begin
        if (mag1 == 16'd0) result_o = {item_i.operand[16], 31'd0};
        else result_o = {item_i.operand[16], ex1, frac_sh[14:0], 8'd0};
      end
      default: result_o = 32'd0;
    endcase
  end

endmodule

>>> rtl/core/float_sign_magnitude_converter.sv
// Float32 / 17-bit sign-magnitude converter.
// Input channel in_if: mode, operand, offset; one result per accepted item on
// out_if (result). Mode 0 converts float32 bits to a sign-magnitude word
// (sign at bit 16), mode 1 converts back to float32; offset moves the scale.
// An accepted item is captured in an input register, converted by one pass
// of combinational logic and written to the result register once that
// register is empty or being taken; throughput one item per cycle while the
// receiver takes results.
// The input stage advances whenever the result register is empty or being
// taken, so in_if.ready stays high while results flow. When the receiver
// stalls, the result holds, the input stage fills and ready drops after it.
// Reset (rst_ni low, asynchronous) empties both stages; payload registers are not reset.
module float_sign_magnitude_converter #(
  parameter int unsigned ScaleBits = fsmc_pkg::ScaleBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fsmc_in_if.sink     in_if,
  fsmc_out_if.source  out_if
);

  fsmc_pkg::in_item_t item_q;
  logic               in_vld_q;
  logic [31:0]        res_d, res_q;
  logic               out_vld_q;
  logic               adv;

  assign adv         = !out_vld_q || out_if.ready;
  assign in_if.ready = !in_vld_q || adv;

  fsmc_convert #(.ScaleBits(ScaleBits)) u_conv (
    .item_i  (item_q),
    .result_o(res_d)
  );

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_if.ready) in_vld_q <= in_if.valid;
      if (adv) out_vld_q <= in_vld_q;
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      item_q <= '{mode: in_if.mode, operand: in_if.operand, offset: in_if.offset};
    end
    if (adv && in_vld_q) res_q <= res_d;
  end

  assign out_if.valid  = out_vld_q;
  assign out_if.result = res_q;

endmodule
